// ===== sv/sbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsc_pkg
// Shared types, codes and symbol tables for the six-bit symbol codec.
// ----------------------------------------------------------------------------
package sbsc_pkg;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  localparam int MaxResults = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       out_last;
    logic       bad_symbol;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] entry;
    logic [2:0]               count;
  } batch_t;

  // {unmapped, code}
  function automatic logic [6:0] symbol_code(input logic [7:0] c);
    logic [6:0] r;
    r = {1'b1, 6'd0};
    if (c == 8'h2D) begin
      r = {1'b0, 6'd0};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b0, 6'(c - 8'h41 + 8'd1)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd27)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd53)};
    end else if (c == 8'h5F) begin
      r = {1'b0, 6'h3F};
    end
    return r;
  endfunction

  function automatic logic [7:0] code_char(input logic [5:0] s);
    logic [7:0] c;
    if (s == 6'd0) begin
      c = 8'h2D;
    end else if (s <= 6'd26) begin
      c = 8'h41 + {2'b00, s} - 8'd1;
    end else if (s <= 6'd52) begin
      c = 8'h61 + {2'b00, s} - 8'd27;
    end else if (s <= 6'd62) begin
      c = 8'h30 + {2'b00, s} - 8'd53;
    end else begin
      c = 8'h5F;
    end
    return c;
  endfunction

endpackage

// ===== sv/sbsc_if.sv =====
// ----------------------------------------------------------------------------
// sbsc_in_if / sbsc_out_if
// Valid/ready channels carrying input characters and codec results.
// ----------------------------------------------------------------------------
interface sbsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sbsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_data;
  logic       out_last;
  logic       bad_symbol;

  modport source (output valid, output out_byte, output has_data, output out_last,
                  output bad_symbol, input ready);
  modport sink   (input valid, input out_byte, input has_data, input out_last,
                  input bad_symbol, output ready);
endinterface

// ===== sv/six_bit_symbol_codec.sv =====
// ----------------------------------------------------------------------------
// six_bit_symbol_codec
// Packs identifier symbols into bytes and unpacks bytes into symbols.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one character (pack) or one byte (unpack) per item, with
//   in_last on the final item of a string. tx carries one result per item:
//   out_byte, has_data (0 only on an end marker), out_last and bad_symbol.
//   cfg_we/cfg_wdata set the direction (0 pack, 1 unpack) while idle; a
//   write drops any open group.
//   An item that closes a group loads a batch of up to four results; the
//   batch drains one result per cycle into the tx output register while
//   that register is empty or tx is ready, so the first result is on tx
//   only after it has moved from the batch into the output register.
//   rx is ready while the batch is empty or its last result is moving out,
//   so items that only extend a group go in every cycle. While a batch
//   drains rx waits, and the next item goes in as the batch's last result
//   moves out. Reset clears the open group, empties the batch and the
//   output register (tx valid low) and sets pack mode. A tx stall holds
//   the output register; the batch waits behind it and rx stalls while the
//   batch holds a result that cannot move.
// ----------------------------------------------------------------------------
module six_bit_symbol_codec (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  sbsc_in_if.sink           rx,
  sbsc_out_if.source        tx
);

  sbsc_pkg::batch_t                       batch;
  sbsc_pkg::result_t [sbsc_pkg::MaxResults-1:0] held;
  logic [2:0]                             remaining;
  logic [1:0]                             head;
  sbsc_pkg::result_t                      out_reg;
  logic                                   out_valid;
  logic                                   move;
  logic                                   accept;

  assign move     = (remaining != 3'd0) && (!out_valid || tx.ready);
  assign rx.ready = (remaining == 3'd0) || ((remaining == 3'd1) && move);
  assign accept   = rx.valid && rx.ready;

  sbsc_group u_group (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_byte   (rx.in_byte),
    .in_last   (rx.in_last),
    .batch     (batch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        remaining <= batch.count;
        head      <= '0;
      end else if (move) begin
        remaining <= remaining - 3'd1;
        head      <= head + 2'd1;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= batch.entry;
    end
    if (move) begin
      out_reg <= held[head];
    end
  end

  assign tx.valid      = out_valid;
  assign tx.out_byte   = out_reg.out_byte;
  assign tx.has_data   = out_reg.has_data;
  assign tx.out_last   = out_reg.out_last;
  assign tx.bad_symbol = out_reg.bad_symbol;

  a_batch_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> remaining == $past(batch.count))
    else $error("batch count not loaded on accept");

  a_move_fills: assert property (@(posedge clk) disable iff (rst)
    move |=> tx.valid)
    else $error("result moved but output not valid");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    tx.valid && !tx.has_data |-> tx.out_last && tx.out_byte == 8'd0)
    else $error("end marker without out_last");

endmodule

// ===== sv/sbsc_group.sv =====
// ----------------------------------------------------------------------------
// sbsc_group
// Group accumulator: holds the open group and direction register, and
// computes the batch of results that the current item produces.
// ----------------------------------------------------------------------------
module sbsc_group (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output sbsc_pkg::batch_t      batch
);

  logic        direction;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic        group_bad;

  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic        group_bad_next;

  logic [6:0]  sym;
  logic [23:0] bits_new;
  logic        bad_new;
  logic        flush;
  logic [2:0]  n;
  logic [5:0]  s [4];
  logic        drop;

  always_comb begin
    sym      = sbsc_pkg::symbol_code(in_byte);
    bits_new = group_bits;
    bad_new  = 1'b0;
    flush    = 1'b0;
    n        = 3'd0;
    drop     = 1'b0;
    batch    = '0;
    for (int j = 0; j < 4; j++) begin
      s[j] = bits_new[23-6*j -: 6];
    end

    if (direction == sbsc_pkg::DIR_PACK) begin
      bad_new = group_bad | sym[6];
      unique case (group_count)
        2'd0: bits_new = group_bits | {sym[5:0], 18'd0};
        2'd1: bits_new = group_bits | {6'd0, sym[5:0], 12'd0};
        2'd2: bits_new = group_bits | {12'd0, sym[5:0], 6'd0};
        2'd3: bits_new = group_bits | {18'd0, sym[5:0]};
      endcase
      flush = (group_count == 2'd3) || in_last;
      n     = (group_count == 2'd3) ? 3'd3 : {1'b0, group_count} + 3'd1;
      for (int j = 0; j < 3; j++) begin
        batch.entry[j].out_byte   = bits_new[23-8*j -: 8];
        batch.entry[j].has_data   = 1'b1;
        batch.entry[j].out_last   = in_last && (3'(j) + 3'd1 == n);
        batch.entry[j].bad_symbol = bad_new;
      end
    end else begin
      unique case (group_count)
        2'd0:    bits_new = group_bits | {in_byte, 16'd0};
        2'd1:    bits_new = group_bits | {8'd0, in_byte, 8'd0};
        default: bits_new = group_bits | {16'd0, in_byte};
      endcase
      for (int j = 0; j < 4; j++) begin
        s[j] = bits_new[23-6*j -: 6];
      end
      flush = (group_count == 2'd2) || in_last;
      unique case (group_count)
        2'd0: begin
          n    = 3'd1;
          drop = in_last && (s[0] == 6'd0);
        end
        2'd1: begin
          n    = 3'd2;
          drop = in_last && (s[1] == 6'd0);
        end
        default: begin
          n    = 3'd4;
          drop = in_last && (s[3] == 6'd0);
        end
      endcase
      if (drop) begin
        n = n - 3'd1;
      end
      if (n == 3'd0) begin
        n = 3'd1;
        batch.entry[0].out_byte   = 8'd0;
        batch.entry[0].has_data   = 1'b0;
        batch.entry[0].out_last   = 1'b1;
        batch.entry[0].bad_symbol = 1'b0;
      end else begin
        for (int j = 0; j < 4; j++) begin
          batch.entry[j].out_byte   = sbsc_pkg::code_char(s[j]);
          batch.entry[j].has_data   = 1'b1;
          batch.entry[j].out_last   = in_last && (3'(j) + 3'd1 == n);
          batch.entry[j].bad_symbol = 1'b0;
        end
      end
    end

    batch.count = flush ? n : 3'd0;
  end

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    group_bad_next   = group_bad;
    if (cfg_we) begin
      group_bits_next  = '0;
      group_count_next = '0;
      group_bad_next   = 1'b0;
    end else if (accept) begin
      if (flush) begin
        group_bits_next  = '0;
        group_count_next = '0;
        group_bad_next   = 1'b0;
      end else begin
        group_bits_next  = bits_new;
        group_count_next = group_count + 2'd1;
        group_bad_next   = bad_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= sbsc_pkg::DIR_PACK;
      group_bits  <= '0;
      group_count <= '0;
      group_bad   <= 1'b0;
    end else begin
      if (cfg_we) begin
        direction <= cfg_wdata;
      end
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      group_bad   <= group_bad_next;
    end
  end

endmodule

// ===== tb/sv/six_bit_symbol_codec_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_bit_symbol_codec_tb
// Self-checking bench for the six-bit symbol codec. Directed strings cover
// the short groups, unmapped characters, the dropped trailing dash, the
// end-marker-only result and direction writes over an open group; random
// strings in both directions follow. Every result is checked in order
// against a local prediction; both channels idle at random before the quiet tail.
// ----------------------------------------------------------------------------
module six_bit_symbol_codec_tb;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 10;
  localparam int RandomItems = 140;
  localparam logic [8*64-1:0] Symbols =
    "-ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_";

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  sbsc_in_if  rx_ch ();
  sbsc_out_if tx_ch ();

  six_bit_symbol_codec uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .rx       (rx_ch),
    .tx       (tx_ch)
  );

  // predicted codec state
  logic        dir_mode;
  logic [23:0] grp_bits;
  int          grp_count;
  logic        grp_bad;

  sbsc_pkg::result_t pending_results[$];
  sbsc_pkg::result_t got_result;
  sbsc_pkg::result_t want_result;
  int      error_count = 0;
  int      cycle_count = 0;
  int      stall_left = 0;
  logic    quiet_tail = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] symbol_char(input logic [5:0] s);
    return Symbols[8*(63-s) +: 8];
  endfunction

  function automatic void char_to_code(input logic [7:0] c, output logic [5:0] code,
                                       output logic bad);
    code = 6'd0;
    bad = 1'b1;
    for (int i = 0; i < 64; i++) begin
      if (symbol_char(6'(i)) == c) begin
        code = 6'(i);
        bad = 1'b0;
      end
    end
  endfunction

  function automatic void clear_group();
    grp_bits = 24'd0;
    grp_count = 0;
    grp_bad = 1'b0;
  endfunction

  task automatic compute_codec_results(input logic [7:0] b, input logic last);
    logic [5:0] code;
    logic       bad;
    int         n;
    sbsc_pkg::result_t r;
    if (dir_mode == sbsc_pkg::DIR_PACK) begin
      char_to_code(b, code, bad);
      grp_bad = grp_bad | bad;
      grp_bits = grp_bits | (24'(code) << (18 - 6 * grp_count));
      grp_count++;
      if (grp_count == 4 || last) begin
        n = (grp_count == 4) ? 3 : grp_count;
        for (int j = 0; j < n; j++) begin
          r.out_byte = grp_bits[16-8*j +: 8];
          r.has_data = 1'b1;
          r.out_last = last && (j == n - 1);
          r.bad_symbol = grp_bad;
          pending_results.push_back(r);
        end
        clear_group();
      end
    end else begin
      grp_bits = grp_bits | (24'(b) << (16 - 8 * grp_count));
      grp_count++;
      if (grp_count == 3 || last) begin
        n = (grp_count == 3) ? 4 : grp_count;
        // trailing dash is dropped
        if (last && grp_bits[18-6*(n-1) +: 6] == 6'd0) n--;
        if (last && n == 0) begin
          r = '{out_byte: 8'h00, has_data: 1'b0, out_last: 1'b1, bad_symbol: 1'b0};
          pending_results.push_back(r);
        end else begin
          for (int j = 0; j < n; j++) begin
            r.out_byte = symbol_char(grp_bits[18-6*j +: 6]);
            r.has_data = 1'b1;
            r.out_last = last && (j == n - 1);
            r.bad_symbol = 1'b0;
            pending_results.push_back(r);
          end
        end
        clear_group();
      end
    end
  endtask

  task automatic drive_codec_item(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.in_byte <= b;
    rx_ch.in_last <= last;
    rx_ch.valid <= 1'b1;
    do @(posedge clk); while (!rx_ch.ready);
    compute_codec_results(b, last);
  endtask

  task automatic wait_results_drained();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_direction(input logic d);
    wait_results_drained();
    cfg_wdata <= d;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    dir_mode = d;
    clear_group();
  endtask

  task automatic test_pack_directed();
    set_direction(sbsc_pkg::DIR_PACK);
    drive_codec_item("-", 1'b1);
    drive_codec_item("A", 1'b0);
    drive_codec_item("_", 1'b0);
    drive_codec_item("z", 1'b0);
    drive_codec_item("0", 1'b0);
    drive_codec_item("9", 1'b1);
    // unmapped characters flag the whole group
    drive_codec_item(8'hFF, 1'b0);
    drive_codec_item("-", 1'b0);
    drive_codec_item(8'h00, 1'b0);
    drive_codec_item("Z", 1'b1);
  endtask

  task automatic test_unpack_directed();
    set_direction(sbsc_pkg::DIR_UNPACK);
    drive_codec_item(8'h00, 1'b1);
    drive_codec_item(8'hFF, 1'b1);
    drive_codec_item(8'h00, 1'b0);
    drive_codec_item(8'h00, 1'b0);
    drive_codec_item(8'h00, 1'b1);
    drive_codec_item(8'hFF, 1'b0);
    drive_codec_item(8'h0F, 1'b1);
    drive_codec_item(8'hFF, 1'b0);
    drive_codec_item(8'hFF, 1'b0);
    drive_codec_item(8'hFF, 1'b0);
    drive_codec_item(8'h04, 1'b1);
  endtask

  task automatic test_direction_switch();
    set_direction(sbsc_pkg::DIR_PACK);
    drive_codec_item("A", 1'b0);
    drive_codec_item("B", 1'b0);
    set_direction(sbsc_pkg::DIR_UNPACK);
    drive_codec_item(8'h12, 1'b0);
    drive_codec_item(8'h34, 1'b0);
    set_direction(sbsc_pkg::DIR_PACK);
    drive_codec_item("C", 1'b1);
  endtask

  task automatic test_random_strings();
    int      sent;
    int      len;
    int      strings;
    logic [7:0] b;
    logic    last;
    sent = 0;
    while (sent < RandomItems) begin
      set_direction(logic'($urandom_range(0, 1)));
      strings = $urandom_range(1, 4);
      for (int s = 0; s < strings; s++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          last = (i == len - 1);
          if (dir_mode == sbsc_pkg::DIR_PACK) begin
            if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
            else b = symbol_char(6'($urandom_range(0, 63)));
          end else begin
            b = 8'($urandom_range(0, 255));
            // steer toward a trailing dash
            if (last && $urandom_range(0, 2) == 0) begin
              case (grp_count)
                0: b = b & 8'h03;
                1: b = b & 8'h0F;
                default: b = b & 8'hC0;
              endcase
            end
          end
          drive_codec_item(b, last);
          sent++;
          if (sent == RandomItems - 40) quiet_tail <= 1'b1;
        end
      end
    end
  endtask

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      tx_ch.ready <= 1'b0;
    end else if (quiet_tail) begin
      tx_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      tx_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      tx_ch.ready <= 1'b0;
    end else begin
      tx_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      got_result = {tx_ch.out_byte, tx_ch.has_data, tx_ch.out_last, tx_ch.bad_symbol};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result byte=%h data=%b last=%b bad=%b", $time,
                 got_result.out_byte, got_result.has_data, got_result.out_last,
                 got_result.bad_symbol);
        error_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.out_byte !== want_result.out_byte ||
            got_result.has_data !== want_result.has_data ||
            got_result.out_last !== want_result.out_last ||
            got_result.bad_symbol !== want_result.bad_symbol) begin
          $display("%0t: mismatch expected byte=%h data=%b last=%b bad=%b", $time,
                   want_result.out_byte, want_result.has_data, want_result.out_last,
                   want_result.bad_symbol);
          $display("%0t:          actual   byte=%h data=%b last=%b bad=%b", $time,
                   got_result.out_byte, got_result.has_data, got_result.out_last,
                   got_result.bad_symbol);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("six_bit_symbol_codec_tb: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.in_byte = 8'h00;
    rx_ch.in_last = 1'b0;
    dir_mode = sbsc_pkg::DIR_PACK;
    clear_group();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pack_directed();
    test_unpack_directed();
    test_direction_switch();
    test_random_strings();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("six_bit_symbol_codec_tb: clean");
    end else begin
      $display("six_bit_symbol_codec_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sbsc_pkg.sv
sv/sbsc_if.sv
sv/sbsc_group.sv
sv/six_bit_symbol_codec.sv
tb/sv/six_bit_symbol_codec_tb.sv
